@@ hw/rtl/aes128_block_cipher_defines.svh @@
// Assertion macros for the AES-128 block cipher checker.
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define AES_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aes128 check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define AES_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aes128 check failed");

`endif

@@ hw/rtl/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// AES package
// S-boxes, round constants and the byte-level round transforms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

	localparam int unsigned NUM_ROUNDS = 10;

	typedef enum logic {
		CFG_KEY_HIGH = 1'b0,
		CFG_KEY_LOW  = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef struct packed {
		logic                          busy;
		logic [NUM_ROUNDS:0][127:0]    rk;
	} aes_keys_t;

	localparam logic [7:0] RCON [NUM_ROUNDS] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of a block sits at bits 127-8i downto 120-8i
	function automatic logic [127:0] sub_block(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		for (int i = 0; i < 16; i++) begin
			t[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
		end
		return t;
	endfunction

	function automatic logic [127:0] shift_block(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (inv)
					t[127-8*(r+4*((c+r)&3)) -: 8] = s[127-8*(r+4*c) -: 8];
				else
					t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)&3)) -: 8];
			end
		end
		return t;
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		logic [31:0] o;
		for (int i = 0; i < 4; i++) begin
			a[i]  = col[31-8*i -: 8];
			x2[i] = xt(a[i]);
			x4[i] = xt(x2[i]);
			x8[i] = xt(x4[i]);
			m9[i] = x8[i] ^ a[i];
			mb[i] = x8[i] ^ x2[i] ^ a[i];
			md[i] = x8[i] ^ x4[i] ^ a[i];
			me[i] = x8[i] ^ x4[i] ^ x2[i];
		end
		for (int i = 0; i < 4; i++) begin
			if (inv)
				o[31-8*i -: 8] = me[i] ^ mb[(i+1)&3] ^ md[(i+2)&3] ^ m9[(i+3)&3];
			else
				o[31-8*i -: 8] = x2[i] ^ x2[(i+1)&3] ^ a[(i+1)&3] ^ a[(i+2)&3]
					^ a[(i+3)&3];
		end
		return o;
	endfunction

	function automatic logic [127:0] mix_block(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		for (int c = 0; c < 4; c++) begin
			t[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
		end
		return t;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/aes_if.sv @@
// ----------------------------------------------------------------------------
// AES stream channels
// Block input channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface aes_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [63:0] data_high;
	logic [63:0] data_low;
	modport source (output valid, operation, data_high, data_low, input ready);
	modport sink (input valid, operation, data_high, data_low, output ready);
endinterface

interface aes_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;
	modport source (output valid, result_high, result_low, input ready);
	modport sink (input valid, result_high, result_low, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/aes_key_exp.sv @@
// ----------------------------------------------------------------------------
// AES key expansion
// Holds the key registers and expands them into round keys, one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aes_key_exp
	import aes_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire cfg_idx_t      cfg_idx,
	input  wire logic [63:0]   cfg_data,
	output aes_keys_t          keys
);
	logic [63:0]  key_high_q;
	logic [63:0]  key_low_q;
	logic [3:0]   cnt_q;
	logic [127:0] last_q;
	logic [127:0] rk_q [NUM_ROUNDS];
	logic [127:0] prev;
	logic [127:0] nxt;
	logic [31:0]  tw;
	logic         busy;

	assign busy = (cnt_q != 4'(NUM_ROUNDS));
	assign prev = (cnt_q == 4'd0) ? {key_high_q, key_low_q} : last_q;

	always_comb begin
		tw = {SBOX[prev[23:16]] ^ RCON[cnt_q], SBOX[prev[15:8]], SBOX[prev[7:0]],
			SBOX[prev[31:24]]};
		nxt[127:96] = prev[127:96] ^ tw;
		nxt[95:64]  = prev[95:64] ^ nxt[127:96];
		nxt[63:32]  = prev[63:32] ^ nxt[95:64];
		nxt[31:0]   = prev[31:0] ^ nxt[63:32];
	end

	// restart the sweep on every key write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			cnt_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
			cnt_q <= '0;
		end else if (busy) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy && !cfg_we) begin
			rk_q[cnt_q] <= nxt;
			last_q      <= nxt;
		end
	end

	always_comb begin
		keys.busy  = busy;
		keys.rk[0] = {key_high_q, key_low_q};
		for (int i = 1; i <= NUM_ROUNDS; i++) begin
			keys.rk[i] = rk_q[i-1];
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/aes_round.sv @@
// ----------------------------------------------------------------------------
// AES round stage
// One encrypt or decrypt round with its pipeline register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aes_round
	import aes_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         take,
	input  wire logic         last,
	input  wire logic         in_valid,
	input  wire op_t          in_op,
	input  wire logic [127:0] in_state,
	input  wire logic [127:0] enc_key,
	input  wire logic [127:0] dec_key,
	output op_t               out_op,
	output logic              out_valid,
	output logic [127:0]      out_state
);
	logic [127:0] enc_mix;
	logic [127:0] enc_res;
	logic [127:0] dec_add;
	logic [127:0] dec_res;
	logic         vld_s;
	op_t          op_s;
	logic [127:0] st_s;

	always_comb begin
		enc_mix = shift_block(sub_block(in_state, 1'b0), 1'b0);
		enc_res = (last ? enc_mix : mix_block(enc_mix, 1'b0)) ^ enc_key;
		dec_add = sub_block(shift_block(in_state, 1'b1), 1'b1) ^ dec_key;
		dec_res = last ? dec_add : mix_block(dec_add, 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (take) begin
			vld_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			op_s <= in_op;
			st_s <= (in_op == OP_DECRYPT) ? dec_res : enc_res;
		end
	end

	assign out_valid = vld_s;
	assign out_op    = op_s;
	assign out_state = st_s;
endmodule
`default_nettype wire

@@ hw/rtl/aes128_block_cipher.sv @@
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Fully unrolled ten-round pipeline with a shared on-chip key schedule.
// ----------------------------------------------------------------------------
//
// Channel   Dir   Payload                               Handshake
// in_ch     in    operation, data_high, data_low        valid/ready
// out_ch    out   result_high, result_low               valid/ready
// cfg       in    cfg_idx (key_high/key_low), cfg_data  cfg_we, no ready
//
// Eleven register stages (key add plus ten rounds) lie between an input transaction
// and out_ch.valid; one block per cycle sustained while out_ch.ready is high and
// no key expansion sweep is running.
// Every key write, and the release of reset, starts a key expansion sweep;
// in_ch.ready stays low until the sweep completes.
// Each stage takes new data when it is empty or its successor moves, so
// bubbles collapse and a stall on out_ch freezes only the stages behind it.
//
`timescale 1ns / 1ps
`default_nettype none
module aes128_block_cipher
	import aes_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire cfg_idx_t    cfg_idx,
	input  wire logic [63:0] cfg_data,
	aes_in_if.sink           in_ch,
	aes_out_if.source        out_ch
);
	aes_keys_t    keys;
	logic         vld [NUM_ROUNDS+1];
	op_t          op [NUM_ROUNDS+1];
	logic [127:0] st [NUM_ROUNDS+1];
	logic         rdy [NUM_ROUNDS+2];
	logic         vld_s0;
	op_t          op_s0;
	logic [127:0] st_s0;
	logic         in_take;

	aes_key_exp u_key (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.keys     (keys)
	);

	// a stage advances when it is empty or the next one advances
	always_comb begin
		rdy[NUM_ROUNDS+1] = out_ch.ready;
		for (int i = NUM_ROUNDS; i >= 0; i--) begin
			rdy[i] = !vld[i] || rdy[i+1];
		end
	end

	// hold off new transactions while the key schedule is being rebuilt
	assign in_ch.ready = rdy[0] && !keys.busy;
	assign in_take     = in_ch.valid && !keys.busy;

	// stage 0: initial key addition, round key 0 or 10 by direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (rdy[0]) begin
			vld_s0 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_take) begin
			op_s0 <= op_t'(in_ch.operation);
			st_s0 <= {in_ch.data_high, in_ch.data_low}
				^ (op_t'(in_ch.operation) == OP_DECRYPT ? keys.rk[NUM_ROUNDS] : keys.rk[0]);
		end
	end

	assign vld[0] = vld_s0;
	assign op[0]  = op_s0;
	assign st[0]  = st_s0;

	// rounds 1..10; decryption walks the schedule backward
	for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
		aes_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.take      (rdy[r]),
			.last      (r == NUM_ROUNDS),
			.in_valid  (vld[r-1]),
			.in_op     (op[r-1]),
			.in_state  (st[r-1]),
			.enc_key   (keys.rk[r]),
			.dec_key   (keys.rk[NUM_ROUNDS-r]),
			.out_op    (op[r]),
			.out_valid (vld[r]),
			.out_state (st[r])
		);
	end

	assign out_ch.valid       = vld[NUM_ROUNDS];
	assign out_ch.result_high = st[NUM_ROUNDS][127:64];
	assign out_ch.result_low  = st[NUM_ROUNDS][63:0];
endmodule
`default_nettype wire

@@ hw/rtl/aes_chk.sv @@
// ----------------------------------------------------------------------------
// AES port checker
// Watches the top-level ports for handshake and key-load behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "aes128_block_cipher_defines.svh"
module aes_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_we,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] out_high,
	input wire logic [63:0] out_low
);
	`AES_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`AES_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_high) && $stable(out_low))
	`AES_ASSERT_NEXT(a_key_busy, cfg_we, !in_ready)
	`AES_ASSERT_NOW(a_idle_ready, !in_valid && !out_valid && in_ready, !cfg_we || in_ready)
endmodule

bind aes128_block_cipher aes_chk u_aes_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_high  (out_ch.result_high),
	.out_low   (out_ch.result_low)
);
`default_nettype wire
